// File: rtl/msba_pkg.sv
package msba_pkg;

    // arena geometry
    localparam int BLOCK_BYTES = 4096;
    localparam int MARK_DEPTH  = 64;
    localparam int BLOCK_COUNT = 16;

    localparam int ALIGN_BYTES = 8;

    // derived widths
    localparam int OFF_W   = $clog2(BLOCK_BYTES) + 1;
    localparam int BLK_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int MARK_AW = $clog2(MARK_DEPTH);
    localparam int REQ_W   = 13;
    localparam int SIZE_W  = REQ_W + 1;
    localparam int SUM_W   = ((OFF_W > SIZE_W) ? OFF_W : SIZE_W) + 1;
    localparam int CNT_W   = 16;

    // beat field widths
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int OBLK_W   = 4;
    localparam int OOFF_W   = 12;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd1;
    localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 3'd2;
    localparam logic [STATUS_W-1:0] STS_NO_PUSH   = 3'd3;
    localparam logic [STATUS_W-1:0] STS_TOO_LARGE = 3'd4;
    localparam logic [STATUS_W-1:0] STS_NO_BLOCKS = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [REQ_W-1:0] request_bytes;
    } cmd_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OBLK_W-1:0]   block_index;
        logic [OOFF_W-1:0]   byte_offset;
        logic [CNT_W-1:0]    depth;
    } res_beat_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop_fin;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/msba_ctrl.sv
module msba_ctrl
    import msba_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic [CMD_W-1:0] command,
    output logic             cmd_stall,
    input  dp_sts_t          sts,
    output ctl_t             ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        cmd_stall   = !((state_reg == S_IDLE) && sts.out_free);
        ctl.accept  = (state_reg == S_IDLE) && cmd_valid && sts.out_free;
        ctl.pop_fin = (state_reg == S_POP) && sts.out_free;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept && (command == CMD_POP))
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/msba_datapath.sv
module msba_datapath
    import msba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_beat_t cmd_beat,
    input  ctl_t      ctl,
    output dp_sts_t   sts,
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_beat
);

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [OFF_W-1:0] off;
    } mark_t;

    mark_t mark_mem [MARK_DEPTH];

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [BLK_W-1:0] blk_reg,  blk_next;
    logic [OFF_W-1:0] off_reg,  off_next;
    logic             out_valid_reg, out_valid_next;
    res_beat_t        out_reg, out_next;
    mark_t            rd_reg;
    logic             pop_empty_reg, pop_stored_reg;

    logic [SIZE_W-1:0] size;
    logic [SUM_W-1:0]  sum;
    logic              too_large, wrap, last_blk;
    logic              full, at_max;
    logic [CNT_W-1:0]  cnt_dec;
    logic              mem_we;
    logic              out_load;

    assign sts.out_free = !out_valid_reg || !res_stall;
    assign res_valid    = out_valid_reg;
    assign res_beat     = out_reg;

    // round up to the alignment
    assign size = (SIZE_W'(cmd_beat.request_bytes) + SIZE_W'(ALIGN_BYTES - 1))
                  & ~SIZE_W'(ALIGN_BYTES - 1);
    assign sum       = SUM_W'(off_reg) + SUM_W'(size);
    assign too_large = SUM_W'(size) > SUM_W'(BLOCK_BYTES);
    assign wrap      = sum >= SUM_W'(BLOCK_BYTES);
    assign last_blk  = blk_reg == BLK_W'(BLOCK_COUNT - 1);
    assign full      = cnt_reg >= CNT_W'(MARK_DEPTH);
    assign at_max    = cnt_reg == {CNT_W{1'b1}};
    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign mem_we    = ctl.accept && (cmd_beat.command == CMD_PUSH) && !full;

    always_comb
    begin
        cnt_next = cnt_reg;
        blk_next = blk_reg;
        off_next = off_reg;
        out_load = 1'b0;
        out_next = out_reg;
        if (ctl.accept)
        begin
            out_load             = (cmd_beat.command != CMD_POP);
            out_next.status      = STS_OK;
            out_next.block_index = OBLK_W'(blk_reg);
            out_next.byte_offset = OOFF_W'(off_reg);
            out_next.depth       = cnt_reg;
            case (cmd_beat.command)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        out_next.status = STS_OVERFLOW;
                    end
                    if (!at_max)
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    out_next.depth = cnt_next;
                end
                CMD_ALLOC:
                begin
                    if (cnt_reg == '0)
                    begin
                        out_next.status = STS_NO_PUSH;
                    end
                    else if (too_large)
                    begin
                        out_next.status = STS_TOO_LARGE;
                    end
                    else if (wrap && last_blk)
                    begin
                        out_next.status = STS_NO_BLOCKS;
                    end
                    else if (wrap)
                    begin
                        blk_next             = blk_reg + BLK_W'(1);
                        off_next             = OFF_W'(size);
                        out_next.block_index = OBLK_W'(blk_next);
                        out_next.byte_offset = '0;
                    end
                    else
                    begin
                        off_next = OFF_W'(sum);
                    end
                end
                CMD_POP:
                begin
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_dec;
                    end
                end
                default:
                begin
                    out_next.status = STS_OK;
                end
            endcase
        end
        else if (ctl.pop_fin)
        begin
            out_load             = 1'b1;
            out_next.status      = pop_empty_reg ? STS_UNDERFLOW : STS_OK;
            out_next.block_index = OBLK_W'(blk_reg);
            out_next.byte_offset = OOFF_W'(off_reg);
            out_next.depth       = cnt_reg;
            // a mark beyond the stored depth keeps the position
            if (!pop_empty_reg && pop_stored_reg)
            begin
                blk_next             = rd_reg.blk;
                off_next             = rd_reg.off;
                out_next.block_index = OBLK_W'(rd_reg.blk);
                out_next.byte_offset = OOFF_W'(rd_reg.off);
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            blk_reg       <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            blk_reg       <= blk_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[cnt_reg[MARK_AW-1:0]] <= '{blk: blk_reg, off: off_reg};
        end
        rd_reg <= mark_mem[cnt_dec[MARK_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (ctl.accept)
        begin
            pop_empty_reg  <= cnt_reg == '0;
            pop_stored_reg <= cnt_dec < CNT_W'(MARK_DEPTH);
        end
    end

endmodule

// File: rtl/mark_stack_bump_allocator_unit.sv
// timing: push, allocate and unused codes show their result beat in the cycle after acceptance,
//   pop after a registered read of the mark store, then restore
// throughput: one command per cycle for push and allocate; pop stalls the next command until
//   its result is loaded (mark store read port); a stalled result beat also holds off commands
// reset: rst_n asynchronous active low clears depth, position and result valid;
//   the mark store is not cleared and holds only what pushes wrote
module mark_stack_bump_allocator_unit
    import msba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // command channel
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd_beat,
    // result channel
    output logic      res_valid,
    input  logic      res_stall,
    output res_beat_t res_beat
);

    // command and status between sequencer and datapath
    ctl_t    ctl;
    dp_sts_t sts;

    // sequencer: takes a beat when idle and the result register can be refilled,
    // and on pop holds off further beats in its pop state while the mark store read completes
    msba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .command   (cmd_beat.command),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // datapath: position and depth registers, mark store, result register
    msba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_beat  (cmd_beat),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat)
    );

endmodule
